/* hdl/abp_pkg.sv */
// Shared types and constants of the alarm annunciator beep pattern block.
// Used by abp_mod_unit, alarm_annunciator_beep_pattern and tb_top; depends on nothing.
package abp_pkg;

    localparam int ST_W   = 3;
    localparam int MASK_W = 4;
    localparam int TICK_W = 32;
    localparam int DUR_W  = 16;
    localparam int CNT_W  = $clog2(MASK_W + 1);
    localparam int STEP_W = $clog2(TICK_W);

    localparam logic [ST_W-1:0] ST_NORMAL    = 3'd0;
    localparam logic [ST_W-1:0] ST_ALARM     = 3'd1;
    localparam logic [ST_W-1:0] ST_FAULT     = 3'd2;
    localparam logic [ST_W-1:0] ST_SAFE_WAIT = 3'd3;

    localparam logic [DUR_W-1:0] DUR_OFF     = 16'd0;
    localparam logic [DUR_W-1:0] DUR_FOREVER = 16'hFFFF;

    typedef struct packed {
        logic busy;
        logic done;
    } abp_mod_stat_t;

endpackage

/* hdl/abp_mod_unit.sv */
// Restoring remainder unit: one quotient bit per cycle over the 32-bit dividend.
// Depends on abp_pkg.
module abp_mod_unit #(
    parameter int REM_W = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [abp_pkg::TICK_W-1:0] dividend,
    input  logic [REM_W-1:0]           divisor,
    output abp_pkg::abp_mod_stat_t     stat,
    output logic [REM_W-1:0]           remainder
);
    import abp_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [TICK_W-1:0] dvd_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_next;

    always_comb
    begin
        trial = {rem_reg[REM_W-2:0], dvd_reg[TICK_W-1]};
        if (trial >= divisor)
        begin
            rem_next = trial - divisor;
        end
        else
        begin
            rem_next = trial;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(TICK_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[TICK_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;

endmodule

/* hdl/alarm_annunciator_beep_pattern.sv */
// Top level of the alarm annunciator: tick sequencer, state and output register.
// Depends on abp_pkg and abp_mod_unit.
//
//  channel   signals                                            flow control
//  input     monitor_state gas_mask valve_request latched_flag  in_valid / in_stall
//            lockout_flag tick_now
//  output    fan_on servo_open buzzer_on led_* (four bits)      out_valid / out_stall
//  config    cfg_wr_en cfg_wr_data (buzzer duration, ms)        write only, no wait
//
// A tick that may beep steps through prep, start, a wait on the remainder unit, one scan step per
// alarming sensor (one for an empty mask) and done; any other tick goes from prep to done.
// The result is offered in the same cycle in which the next input transfer can first happen.
// Reset clears the state, the duration register, the output valid flag and the restart tracking registers.
// A result waiting under out_stall does not hold off the next input transfer; the
// sequencer stalls only when a new result is ready and the output is still full.
module alarm_annunciator_beep_pattern #(
    parameter int SENSOR_COUNT = 4,
    parameter int TICK_MS      = 10,
    parameter int BEEP_STEP    = 30,
    parameter int BEEP_ON      = 15,
    parameter int BEEP_GAP     = 100
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [abp_pkg::DUR_W-1:0]  cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [abp_pkg::ST_W-1:0]   monitor_state,
    input  logic [abp_pkg::MASK_W-1:0] gas_mask,
    input  logic                       valve_request,
    input  logic                       latched_flag,
    input  logic                       lockout_flag,
    input  logic [abp_pkg::TICK_W-1:0] tick_now,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       fan_on,
    output logic                       servo_open,
    output logic                       buzzer_on,
    output logic                       led_normal,
    output logic                       led_warning,
    output logic                       led_alarm,
    output logic                       led_valve
);
    import abp_pkg::*;

    localparam int PER_MAX = MASK_W * BEEP_STEP + BEEP_GAP;
    localparam int CMP_W   = $clog2(PER_MAX + BEEP_ON + 1) + 1;
    localparam int PROD_W  = DUR_W + 1 + $clog2(TICK_MS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_START,
        S_WAIT,
        S_SCAN,
        S_DONE
    } seq_state_t;

    seq_state_t state;

    logic [DUR_W-1:0]  dur_reg;
    logic              was_active_reg;
    logic [TICK_W-1:0] start_tick_reg;
    logic [MASK_W-1:0] prev_mask_reg;

    logic [TICK_W-1:0] elapsed_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CMP_W-1:0]  period_reg;
    logic [CMP_W-1:0]  win_lo_reg;
    logic              fault_reg;
    logic              active_reg;
    logic              fan_reg;
    logic              open_reg;
    logic              ln_reg;
    logic              lw_reg;
    logic              buzz_reg;

    logic              out_valid_reg;
    logic              fan_out_reg;
    logic              open_out_reg;
    logic              buzz_out_reg;
    logic              ln_out_reg;
    logic              lw_out_reg;
    logic              la_out_reg;

    logic              in_xfer;
    logic              active_in;
    logic              restart;
    logic [TICK_W-1:0] start_tick_next;
    logic [CNT_W-1:0]  cnt_raw;
    logic [CNT_W-1:0]  cnt_next;
    logic [DUR_W:0]    el_p1;
    logic [PROD_W-1:0] dur_prod;
    logic              dur_ok;
    logic              mod_start;
    abp_mod_stat_t     mod_stat;
    logic [CMP_W-1:0]  phase;
    logic              hit;
    logic              out_free;

    assign in_xfer   = in_valid && (state == S_IDLE);
    assign in_stall  = (state != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign mod_start = (state == S_START);

    always_comb
    begin
        active_in       = monitor_state inside {ST_ALARM, ST_FAULT};
        restart         = active_in && (!was_active_reg || |(gas_mask & ~prev_mask_reg));
        start_tick_next = restart ? tick_now : start_tick_reg;
        cnt_raw         = '0;
        for (int i = 0; i < MASK_W; i++)
        begin
            if (i < SENSOR_COUNT && gas_mask[i])
            begin
                cnt_raw = cnt_raw + 1'b1;
            end
        end
        cnt_next = (cnt_raw == '0) ? CNT_W'(1) : cnt_raw;
    end

    always_comb
    begin
        el_p1    = {1'b0, elapsed_reg[DUR_W-1:0]} + (DUR_W+1)'(1);
        dur_prod = PROD_W'(el_p1) * PROD_W'(TICK_MS);
        dur_ok   = (dur_reg == DUR_FOREVER)
                   || ((elapsed_reg[TICK_W-1:DUR_W] == '0) && (dur_prod <= PROD_W'(dur_reg)));
        hit      = (phase >= win_lo_reg) && (phase < win_lo_reg + CMP_W'(BEEP_ON));
    end

    abp_mod_unit #(
        .REM_W (CMP_W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (elapsed_reg),
        .divisor   (period_reg),
        .stat      (mod_stat),
        .remainder (phase)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state          <= S_IDLE;
            dur_reg        <= DUR_OFF;
            was_active_reg <= 1'b0;
            start_tick_reg <= '0;
            prev_mask_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                dur_reg <= cfg_wr_data;
            end
            if (out_valid_reg && !out_stall && (state != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        was_active_reg <= active_in;
                        prev_mask_reg  <= active_in ? gas_mask : '0;
                        start_tick_reg <= start_tick_next;
                        state          <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    if (fault_reg || !active_reg || !dur_ok)
                    begin
                        state <= S_DONE;
                    end
                    else
                    begin
                        state <= S_START;
                    end
                end
                S_START:
                begin
                    state <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (mod_stat.done)
                    begin
                        state <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (idx_reg == cnt_reg - 1'b1)
                    begin
                        state <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state         <= S_IDLE;
                    end
                end
                default:
                begin
                    state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    elapsed_reg <= tick_now - start_tick_next;
                    cnt_reg     <= cnt_next;
                    fault_reg   <= (monitor_state == ST_FAULT);
                    active_reg  <= active_in;
                    fan_reg     <= active_in || (monitor_state == ST_SAFE_WAIT)
                                   || latched_flag || lockout_flag;
                    open_reg    <= valve_request;
                    ln_reg      <= (monitor_state == ST_NORMAL);
                    lw_reg      <= !active_in && (monitor_state != ST_NORMAL);
                end
            end
            S_PREP:
            begin
                period_reg <= CMP_W'(cnt_reg) * CMP_W'(BEEP_STEP) + CMP_W'(BEEP_GAP);
                buzz_reg   <= fault_reg && (dur_reg != DUR_OFF);
                idx_reg    <= '0;
                win_lo_reg <= '0;
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    buzz_reg <= 1'b1;
                end
                idx_reg    <= idx_reg + 1'b1;
                win_lo_reg <= win_lo_reg + CMP_W'(BEEP_STEP);
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    fan_out_reg  <= fan_reg;
                    open_out_reg <= open_reg;
                    buzz_out_reg <= buzz_reg;
                    ln_out_reg   <= ln_reg && !fault_reg;
                    lw_out_reg   <= lw_reg && !fault_reg;
                    la_out_reg   <= active_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign fan_on      = fan_out_reg;
    assign servo_open  = open_out_reg;
    assign buzzer_on   = buzz_out_reg;
    assign led_normal  = ln_out_reg;
    assign led_warning = lw_out_reg;
    assign led_alarm   = la_out_reg;
    assign led_valve   = open_out_reg;

    a_phase_below_period: assert property (@(posedge clk) disable iff (!rst_n)
        mod_stat.done |-> (phase < period_reg))
        else $error("remainder not below period");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state == S_SCAN) |-> (idx_reg < cnt_reg))
        else $error("window scan past last beep");

    a_wait_has_unit: assert property (@(posedge clk) disable iff (!rst_n)
        (state == S_WAIT) |-> (mod_stat.busy || mod_stat.done))
        else $error("waiting on an idle remainder unit");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state) == S_DONE))
        else $error("result raised outside the done step");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench of alarm_annunciator_beep_pattern: a directed table, then
// random tick sequences under several buzzer durations, checked against a predictor.
// Depends on abp_pkg and the RTL of alarm_annunciator_beep_pattern.
module tb_top;

    import abp_pkg::*;

    localparam int SENSOR_COUNT = 4;
    localparam int TICK_MS      = 10;
    localparam int BEEP_STEP    = 30;
    localparam int BEEP_ON      = 15;
    localparam int BEEP_GAP     = 100;

    localparam logic [ST_W-1:0] ST_OTHER   = 3'd4;
    localparam logic [ST_W-1:0] ST_UNDEF_5 = 3'd5;
    localparam logic [ST_W-1:0] ST_UNDEF_6 = 3'd6;
    localparam logic [ST_W-1:0] ST_UNDEF_7 = 3'd7;

    localparam int N_DIRECTED = 25;
    localparam int N_PHASES   = 13;
    localparam int PHASE_LEN  = 48;

    typedef struct packed {
        logic [ST_W-1:0]   st;
        logic [MASK_W-1:0] mask;
        logic              valve;
        logic              latched;
        logic              lockout;
        logic [TICK_W-1:0] tick;
    } tick_in_t;

    typedef struct packed {
        logic fan;
        logic servo;
        logic buzzer;
        logic led_normal;
        logic led_warning;
        logic led_alarm;
        logic led_valve;
    } annun_t;

    typedef struct packed {
        logic              wr;
        logic [DUR_W-1:0]  dur;
        logic [ST_W-1:0]   st;
        logic [MASK_W-1:0] mask;
        logic [2:0]        flags;
        logic [TICK_W-1:0] tick;
        logic              typed;
        annun_t            exp;
    } stim_row_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                cfg_wr_en     = 1'b0;
    logic [DUR_W-1:0]    cfg_wr_data   = '0;
    logic                in_valid      = 1'b0;
    logic                in_stall;
    logic [ST_W-1:0]     monitor_state = '0;
    logic [MASK_W-1:0]   gas_mask      = '0;
    logic                valve_request = 1'b0;
    logic                latched_flag  = 1'b0;
    logic                lockout_flag  = 1'b0;
    logic [TICK_W-1:0]   tick_now      = '0;
    logic                out_valid;
    logic                out_stall     = 1'b0;
    logic                fan_on;
    logic                servo_open;
    logic                buzzer_on;
    logic                led_normal;
    logic                led_warning;
    logic                led_alarm;
    logic                led_valve;

    logic                pr_active;
    logic [TICK_W-1:0]   pr_start;
    logic [MASK_W-1:0]   pr_prev_mask;
    logic [DUR_W-1:0]    pr_dur;

    annun_t              pending_annun [$];
    annun_t              seen;
    annun_t              want;
    int unsigned         fails      = 0;
    int unsigned         n_ticks    = 0;
    int unsigned         n_beeps    = 0;
    int unsigned         n_settings = 0;
    logic                calm       = 1'b0;

    logic [TICK_W-1:0]   walk_tick;
    logic [ST_W-1:0]     walk_st;
    logic [MASK_W-1:0]   walk_mask;
    logic [DUR_W-1:0]    dur_plan [N_PHASES];

    // wr  duration        state          mask   vr/lat/lock  tick          typed  fan..valve
    stim_row_t dir_tab [N_DIRECTED] = '{
        '{1'b0, 16'd0,      ST_NORMAL,    4'h0,  3'b000, 32'h0000_0000, 1'b1, 7'b0001000},
        '{1'b0, 16'd0,      ST_NORMAL,    4'hF,  3'b110, 32'h0000_0001, 1'b1, 7'b1101001},
        '{1'b0, 16'd0,      ST_SAFE_WAIT, 4'h0,  3'b000, 32'h0000_0002, 1'b1, 7'b1000100},
        '{1'b0, 16'd0,      ST_OTHER,     4'h5,  3'b001, 32'h0000_0003, 1'b1, 7'b1000100},
        '{1'b0, 16'd0,      ST_UNDEF_5,   4'h0,  3'b100, 32'h0000_0004, 1'b1, 7'b0100101},
        '{1'b0, 16'd0,      ST_UNDEF_6,   4'h0,  3'b010, 32'h0000_0005, 1'b1, 7'b1000100},
        '{1'b0, 16'd0,      ST_UNDEF_7,   4'hF,  3'b111, 32'h7FFF_FFFF, 1'b1, 7'b1100101},
        '{1'b0, 16'd0,      ST_FAULT,     4'hF,  3'b000, 32'hFFFF_FFFF, 1'b1, 7'b1000010},
        '{1'b0, 16'd0,      ST_ALARM,     4'hF,  3'b000, 32'h0000_0000, 1'b1, 7'b1000010},
        '{1'b1, DUR_FOREVER, ST_FAULT,    4'h0,  3'b100, 32'h0000_000A, 1'b1, 7'b1110011},
        '{1'b0, 16'd0,      ST_NORMAL,    4'h0,  3'b000, 32'h0000_000B, 1'b1, 7'b0001000},
        '{1'b0, 16'd0,      ST_ALARM,     4'h1,  3'b000, 32'h0000_0064, 1'b1, 7'b1010010},
        '{1'b0, 16'd0,      ST_ALARM,     4'h1,  3'b000, 32'h0000_0072, 1'b0, 7'b0},
        '{1'b0, 16'd0,      ST_ALARM,     4'h1,  3'b000, 32'h0000_0073, 1'b0, 7'b0},
        '{1'b0, 16'd0,      ST_ALARM,     4'h3,  3'b000, 32'h0000_0082, 1'b0, 7'b0},
        '{1'b0, 16'd0,      ST_ALARM,     4'h3,  3'b000, 32'h0000_00A0, 1'b0, 7'b0},
        '{1'b0, 16'd0,      ST_ALARM,     4'h3,  3'b000, 32'h0000_00AF, 1'b0, 7'b0},
        '{1'b0, 16'd0,      ST_ALARM,     4'h0,  3'b000, 32'h0000_00C8, 1'b0, 7'b0},
        '{1'b0, 16'd0,      ST_ALARM,     4'hF,  3'b000, 32'hFFFF_FFF0, 1'b0, 7'b0},
        '{1'b0, 16'd0,      ST_ALARM,     4'hF,  3'b000, 32'h0000_0020, 1'b0, 7'b0},
        '{1'b1, 16'd1,      ST_ALARM,     4'h8,  3'b000, 32'h0000_0025, 1'b0, 7'b0},
        '{1'b1, 16'd200,    ST_NORMAL,    4'h0,  3'b000, 32'h0000_0000, 1'b1, 7'b0001000},
        '{1'b0, 16'd0,      ST_ALARM,     4'h2,  3'b000, 32'h0000_03E8, 1'b1, 7'b1010010},
        '{1'b0, 16'd0,      ST_ALARM,     4'h2,  3'b000, 32'h0000_03FB, 1'b0, 7'b0},
        '{1'b0, 16'd0,      ST_ALARM,     4'hA,  3'b000, 32'h0000_03FD, 1'b0, 7'b0}
    };

    alarm_annunciator_beep_pattern #(
        .SENSOR_COUNT (SENSOR_COUNT),
        .TICK_MS      (TICK_MS),
        .BEEP_STEP    (BEEP_STEP),
        .BEEP_ON      (BEEP_ON),
        .BEEP_GAP     (BEEP_GAP)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .monitor_state (monitor_state),
        .gas_mask      (gas_mask),
        .valve_request (valve_request),
        .latched_flag  (latched_flag),
        .lockout_flag  (lockout_flag),
        .tick_now      (tick_now),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .fan_on        (fan_on),
        .servo_open    (servo_open),
        .buzzer_on     (buzzer_on),
        .led_normal    (led_normal),
        .led_warning   (led_warning),
        .led_alarm     (led_alarm),
        .led_valve     (led_valve)
    );

    always #4 clk = ~clk;

    function automatic logic beep_window(input logic [TICK_W-1:0] elapsed,
                                         input logic [MASK_W-1:0] mask);
        int unsigned beeps;
        int unsigned period;
        int unsigned ph;
        logic        hit;
        beeps = 0;
        hit   = 1'b0;
        for (int i = 0; i < SENSOR_COUNT && i < MASK_W; i++)
        begin
            if (mask[i])
                beeps++;
        end
        if (beeps == 0)
            beeps = 1;
        period = beeps * BEEP_STEP + BEEP_GAP;
        ph     = elapsed % period;
        for (int unsigned i = 0; i < beeps; i++)
        begin
            if (ph >= i * BEEP_STEP && ph < i * BEEP_STEP + BEEP_ON)
                hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic annun_t predict_annunciation(input tick_in_t t);
        annun_t            r;
        logic              active;
        logic [TICK_W-1:0] elapsed;
        logic [TICK_W-1:0] dur_ticks;
        active = (t.st == ST_ALARM) || (t.st == ST_FAULT);
        if (active && (!pr_active || (t.mask & ~pr_prev_mask) != '0))
            pr_start = t.tick;
        pr_active    = active;
        pr_prev_mask = active ? t.mask : '0;

        r.fan       = active || t.st == ST_SAFE_WAIT || t.latched || t.lockout;
        r.servo     = t.valve;
        r.led_valve = t.valve;
        r.buzzer    = 1'b0;
        if (t.st == ST_FAULT)
        begin
            r.buzzer      = (pr_dur != DUR_OFF);
            r.led_normal  = 1'b0;
            r.led_warning = 1'b0;
            r.led_alarm   = 1'b1;
        end
        else
        begin
            elapsed   = t.tick - pr_start;
            dur_ticks = 32'(pr_dur) / 32'(TICK_MS);
            if (active && (pr_dur == DUR_FOREVER || elapsed < dur_ticks))
                r.buzzer = beep_window(elapsed, t.mask);
            r.led_normal  = (t.st == ST_NORMAL);
            r.led_warning = !active && t.st != ST_NORMAL;
            r.led_alarm   = active;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic e, input logic a);
        if (e !== a)
        begin
            $error("%s mismatch: expected %0b, got %0b", name, e, a);
            fails++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen = '{fan_on, servo_open, buzzer_on, led_normal, led_warning, led_alarm,
                     led_valve};
            n_beeps += buzzer_on;
            if (pending_annun.size() == 0)
            begin
                $error("output transfer with no pending expectation");
                fails++;
            end
            else
            begin
                want = pending_annun.pop_front();
                check_field("fan_on",      want.fan,         seen.fan);
                check_field("servo_open",  want.servo,       seen.servo);
                check_field("buzzer_on",   want.buzzer,      seen.buzzer);
                check_field("led_normal",  want.led_normal,  seen.led_normal);
                check_field("led_warning", want.led_warning, seen.led_warning);
                check_field("led_alarm",   want.led_alarm,   seen.led_alarm);
                check_field("led_valve",   want.led_valve,   seen.led_valve);
            end
        end
    end

    initial
    begin : rx_stall
        int unsigned pick;
        int unsigned len;
        logic        lvl;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                lvl = 1'b0;
                len = $urandom_range(1, 12);
            end
            else if (pick < 60)
            begin
                lvl = 1'b0;
                len = $urandom_range(100, 300);
            end
            else if (pick < 93)
            begin
                lvl = 1'b1;
                len = $urandom_range(1, 3);
            end
            else
            begin
                lvl = 1'b1;
                len = $urandom_range(20, 80);
            end
            out_stall <= lvl;
            repeat (len) @(posedge clk);
        end
    end

    task automatic send_tick(input tick_in_t t, input logic typed, input annun_t typed_exp);
        int unsigned gap;
        int unsigned pick;
        annun_t      p;
        gap = 0;
        if (!calm)
        begin
            pick = $urandom_range(0, 99);
            if (pick >= 92)
                gap = $urandom_range(10, 60);
            else if (pick >= 55)
                gap = $urandom_range(1, 3);
        end
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        monitor_state <= t.st;
        gas_mask      <= t.mask;
        valve_request <= t.valve;
        latched_flag  <= t.latched;
        lockout_flag  <= t.lockout;
        tick_now      <= t.tick;
        do
            @(posedge clk);
        while (in_stall);
        p = predict_annunciation(t);
        pending_annun.push_back(typed ? typed_exp : p);
        n_ticks++;
    endtask

    // Drain every pending result before touching the duration register.
    task automatic set_duration(input logic [DUR_W-1:0] v);
        in_valid <= 1'b0;
        while (pending_annun.size() != 0)
            @(posedge clk);
        repeat (48) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        pr_dur = v;
        n_settings++;
    endtask

    task automatic random_phase(input int unsigned n_items);
        tick_in_t    t;
        int unsigned pick;
        int unsigned k;
        walk_tick = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 300)
                                                : $urandom;
        walk_st   = ST_ALARM;
        walk_mask = MASK_W'($urandom_range(1, 15));
        for (k = 0; k < n_items; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                t.st   = ST_W'($urandom_range(0, 7));
                t.mask = MASK_W'($urandom);
                t.tick = $urandom;
            end
            else
            begin
                if ($urandom_range(0, 99) < 8)
                begin
                    pick = $urandom_range(0, 19);
                    if (pick < 10)
                        walk_st = ST_ALARM;
                    else if (pick < 13)
                        walk_st = ST_NORMAL;
                    else if (pick < 16)
                        walk_st = ST_FAULT;
                    else if (pick < 18)
                        walk_st = ST_SAFE_WAIT;
                    else
                        walk_st = ST_W'($urandom_range(ST_OTHER, ST_UNDEF_7));
                end
                if ($urandom_range(0, 99) < 10)
                begin
                    case ($urandom_range(0, 2))
                        0:       walk_mask = walk_mask | (MASK_W'(1) << $urandom_range(0, 3));
                        1:       walk_mask = walk_mask & ~(MASK_W'(1) << $urandom_range(0, 3));
                        default: walk_mask = MASK_W'($urandom);
                    endcase
                end
                pick = $urandom_range(0, 99);
                if (pick < 90)
                    walk_tick = walk_tick + $urandom_range(1, 6);
                else if (pick < 97)
                    walk_tick = walk_tick + $urandom_range(7, 400);
                else
                    walk_tick = $urandom;
                t.st   = walk_st;
                t.mask = walk_mask;
                t.tick = walk_tick;
            end
            t.valve   = 1'($urandom_range(0, 1));
            t.latched = 1'($urandom_range(0, 1));
            t.lockout = 1'($urandom_range(0, 1));
            send_tick(t, 1'b0, '0);
        end
    endtask

    initial
    begin
        #8_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t r;
        tick_in_t  t;
        int        i;
        pr_active    = 1'b0;
        pr_start     = '0;
        pr_prev_mask = '0;
        pr_dur       = DUR_OFF;
        dur_plan = '{DUR_FOREVER, DUR_OFF, 16'd10, 16'd2000, 16'd1, 16'hFFFE, 16'd500,
                     16'd9, 16'd1500, 16'd0, 16'd0, DUR_FOREVER, 16'd3000};
        dur_plan[9]  = DUR_W'($urandom_range(0, 65535));
        dur_plan[10] = DUR_W'($urandom_range(10, 3000));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < N_DIRECTED; i++)
        begin
            r = dir_tab[i];
            if (r.wr)
                set_duration(r.dur);
            t = '{r.st, r.mask, r.flags[2], r.flags[1], r.flags[0], r.tick};
            send_tick(t, r.typed, r.exp);
        end

        for (i = 0; i < N_PHASES; i++)
        begin
            set_duration(dur_plan[i]);
            calm = ($urandom_range(0, 3) == 0);
            random_phase(PHASE_LEN);
        end

        in_valid <= 1'b0;
        while (pending_annun.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        $display("Run covered %0d tick transfers (%0d from the directed table) over %0d duration settings.",
                 n_ticks, N_DIRECTED, n_settings);
        $display("Buzzer was on in %0d results; %0d field mismatches seen.", n_beeps, fails);
        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
